>>> hdl/pta_pkg.sv
// ----------------------------------------------------------------------------
// pta_pkg
// Shared types and constants for the periodic trigger accumulator.
// ----------------------------------------------------------------------------
package pta_pkg;

  localparam int TICK_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  // One quotient bit per divider step
  localparam int DIV_STEPS = TICK_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 1'b1;

  // Reset values of the registers
  localparam logic [TICK_W-1:0]  PERIOD_RESET = 32'd1000;
  localparam logic [COUNT_W-1:0] MAX_RESET    = 16'd16;

  // Saturation limit of the pending count
  localparam logic [COUNT_W-1:0] PENDING_SAT = 16'hFFFF;

  // Item function codes
  localparam logic FUNC_TIME    = 1'b0;
  localparam logic FUNC_CONSUME = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the item, start the divide
    logic step;    // one restoring divide step
    logic commit;  // update state and load the output register
  } pta_cmd_t;

endpackage

>>> hdl/pta_dp.sv
// ----------------------------------------------------------------------------
// pta_dp
// Datapath: configuration registers, state, a bit-serial restoring divider
// for elapsed / period, and the result register.
// ----------------------------------------------------------------------------
module pta_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  pta_pkg::pta_cmd_t              cmd,
  input  logic                           cfg_we,
  input  logic [pta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pta_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           func,
  input  logic [pta_pkg::TICK_W-1:0]     now_ms,
  output logic [pta_pkg::COUNT_W-1:0]    pending_before,
  output logic [pta_pkg::COUNT_W-1:0]    pending_after,
  output logic                           too_many
);
  import pta_pkg::*;

  logic [TICK_W-1:0]  period_ticks;
  logic [COUNT_W-1:0] max_pending;
  logic [TICK_W-1:0]  last_tick;
  logic [COUNT_W-1:0] pending_count;

  logic               func_q;
  logic [TICK_W-1:0]  now_q;
  logic [TICK_W-1:0]  quo;
  logic [TICK_W-1:0]  rem;

  logic [TICK_W:0]    trial;
  logic [TICK_W:0]    shifted;
  logic [COUNT_W:0]   sum;
  logic               sat;
  logic [COUNT_W-1:0] dec;
  logic [COUNT_W-1:0] count_next;
  logic [TICK_W-1:0]  last_tick_next;
  logic               flag_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks <= PERIOD_RESET;
      max_pending  <= MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD: period_ticks <= cfg_data[TICK_W-1:0];
        CFG_MAX:    max_pending  <= cfg_data[COUNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Divider step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem, quo[TICK_W-1]};
  assign trial   = shifted - {1'b0, period_ticks};

  // Item capture and divider iteration
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      now_q  <= now_ms;
      quo    <= now_ms - last_tick;
      rem    <= '0;
    end else if (cmd.step) begin
      if (!trial[TICK_W]) begin
        rem <= trial[TICK_W-1:0];
        quo <= {quo[TICK_W-2:0], 1'b1};
      end else begin
        rem <= shifted[TICK_W-1:0];
        quo <= {quo[TICK_W-2:0], 1'b0};
      end
    end
  end

  // Saturating add of whole periods
  assign sum = {1'b0, pending_count} + {1'b0, quo[COUNT_W-1:0]};
  assign sat = (|quo[TICK_W-1:COUNT_W]) || sum[COUNT_W];
  assign dec = pending_count - 1'b1;

  // Next state for either item kind
  always_comb begin
    count_next     = pending_count;
    last_tick_next = last_tick;
    flag_next      = 1'b0;
    if (func_q == FUNC_CONSUME) begin
      flag_next = (pending_count > max_pending);
      if (pending_count != '0) begin
        count_next = (dec < max_pending) ? dec : max_pending;
      end
    end else if (period_ticks != '0) begin
      // last + q*period equals now - remainder
      last_tick_next = now_q - rem;
      count_next     = sat ? PENDING_SAT : sum[COUNT_W-1:0];
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_tick     <= '0;
      pending_count <= '0;
    end else if (cmd.commit) begin
      last_tick     <= last_tick_next;
      pending_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pending_before <= pending_count;
      pending_after  <= count_next;
      too_many       <= flag_next;
    end
  end

endmodule

>>> hdl/pta_ctrl.sv
// ----------------------------------------------------------------------------
// pta_ctrl
// Controller: sequences load, divide steps and commit, and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module pta_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  output logic              out_valid,
  input  logic              out_stall,
  output pta_pkg::pta_cmd_t cmd
);
  import pta_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] cnt;
  logic              accept;
  logic              out_free;
  logic              last_step;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign last_step = (cnt == STEP_W'(DIV_STEPS - 1));

  assign cmd.load   = accept;
  assign cmd.step   = (state == S_DIV);
  assign cmd.commit = (state == S_FIN) && out_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (func == FUNC_CONSUME) ? S_FIN : S_DIV;
        end
      end
      S_DIV: begin
        if (last_step) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divide step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if (state == S_DIV) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Output valid: set on commit, cleared when the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_consume_fin: assert property (@(posedge clk) disable iff (rst)
    accept && (func == FUNC_CONSUME) |=> state == S_FIN)
    else $error("consume did not go straight to commit");

  a_time_div: assert property (@(posedge clk) disable iff (rst)
    accept && (func == FUNC_TIME) |=> (state == S_DIV) && (cnt == '0))
    else $error("time update did not start the divider");

  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && out_valid && out_stall |=> state == S_FIN)
    else $error("result committed over a waiting output");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid && (state == S_IDLE))
    else $error("commit did not present a result");
`endif

endmodule

>>> hdl/periodic_trigger_accumulator.sv
// ----------------------------------------------------------------------------
// periodic_trigger_accumulator
// Counts whole timer periods from a millisecond tick and hands them out one
// consume at a time.
// ----------------------------------------------------------------------------
// A time update item goes from acceptance to result through a load, 32 steps
// of the bit-serial restoring divider (one quotient bit per cycle), and a
// commit. A consume item takes a load and a commit. One item is in work at a
// time; the next is accepted once the previous one has committed into the
// output register, which then waits for its transaction independently.
// Configuration writes are taken at any time and must be made while idle.
// ----------------------------------------------------------------------------
module periodic_trigger_accumulator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pta_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [pta_pkg::TICK_W-1:0]     now_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pta_pkg::COUNT_W-1:0]    pending_before,
  output logic [pta_pkg::COUNT_W-1:0]    pending_after,
  output logic                           too_many
);
  import pta_pkg::*;

  pta_cmd_t cmd;

  // Sequencer
  pta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Divider, state and result register
  pta_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .func           (func),
    .now_ms         (now_ms),
    .pending_before (pending_before),
    .pending_after  (pending_after),
    .too_many       (too_many)
  );

endmodule
